FILE: hdl/lpsf_pkg.sv
// Package for the line position substring finder.
// Widths, register indexes and byte constants shared by the design.
// No dependencies.
package lpsf_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int PTR_W       = 3;
	localparam int LEN_W       = 4;
	localparam int CHAR_W      = 8;
	localparam int COUNT_W     = 16;
	localparam int PAT_W       = MAX_PATTERN * CHAR_W;

	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [LEN_W-1:0]   len_t;

	localparam char_t  NEWLINE_CHAR = 8'd10;
	localparam count_t COUNT_MAX    = 16'hFFFF;
	localparam len_t   LEN_MAX      = len_t'(MAX_PATTERN);

	localparam logic REG_PATTERN_BYTES  = 1'b0;
	localparam logic REG_PATTERN_LENGTH = 1'b1;

endpackage

FILE: hdl/line_position_substring_finder.sv
// Line position substring finder: one text word per cycle, row/column tracking, window match.
// Depends on lpsf_pkg.
// Flow: an accepted word is held in the input register; its match, if any, is loaded into
// the result register when the word leaves the input register.
// Throughput: one word per cycle; the input stage stalls only when a match meets a full
// result register that is not being taken.
// Reset (arst_n low, asynchronous): row 1, column 0, empty window, pattern length 1,
// pattern bytes zero, input and result registers empty.
module line_position_substring_finder
	import lpsf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic               cfg_index,
	input  logic [PAT_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CHAR_W-1:0]  text_byte,
	input  logic               file_start,
	input  logic [CHAR_W-1:0]  file_number,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  match_file,
	output logic [COUNT_W-1:0] match_row,
	output logic [COUNT_W-1:0] match_column
);

	logic [PAT_W-1:0] pattern_q;
	len_t             pat_len_q;

	logic   valid_s1;
	char_t  byte_s1;
	logic   start_s1;
	char_t  file_s1;

	char_t  win_q [MAX_PATTERN];
	len_t   win_cnt_q;
	count_t row_q;
	count_t col_q;

	char_t  win_next [MAX_PATTERN];
	len_t   len;
	len_t   cnt_base;
	len_t   cnt_inc;
	len_t   cnt_next;
	count_t row_base;
	count_t col_base;
	count_t row_next;
	count_t col_next;
	logic   is_newline;
	logic   cmp_ok;
	logic   hit;
	logic   advance;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			pat_len_q <= len_t'(1);
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_PATTERN_BYTES:  pattern_q <= cfg_data;
				REG_PATTERN_LENGTH: pat_len_q <= cfg_data[LEN_W-1:0];
				default:            pattern_q <= pattern_q;
			endcase
		end
	end

	always_comb begin
		if (pat_len_q == '0)
			len = len_t'(1);
		else if (pat_len_q > LEN_MAX)
			len = LEN_MAX;
		else
			len = pat_len_q;
	end

	assign is_newline = (byte_s1 == NEWLINE_CHAR);
	assign row_base   = start_s1 ? count_t'(1) : row_q;
	assign col_base   = start_s1 ? '0 : col_q;
	assign cnt_base   = start_s1 ? '0 : win_cnt_q;
	assign cnt_inc    = (cnt_base < LEN_MAX) ? cnt_base + len_t'(1) : cnt_base;

	always_comb begin
		win_next[0] = byte_s1;
		for (int k = 1; k < MAX_PATTERN; k++)
			win_next[k] = win_q[k-1];
	end

	// newest len bytes against the pattern, first pattern byte oldest
	always_comb begin
		logic [PTR_W-1:0] sel;
		cmp_ok = 1'b1;
		sel    = '0;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (len_t'(j) < len) begin
				sel = PTR_W'(len - len_t'(1) - len_t'(j));
				if (win_next[sel] != pattern_q[CHAR_W*j +: CHAR_W])
					cmp_ok = 1'b0;
			end
		end
	end

	assign hit = valid_s1 && !is_newline && (cnt_inc >= len) && cmp_ok;

	always_comb begin
		if (is_newline) begin
			row_next = (row_base < COUNT_MAX) ? row_base + count_t'(1) : row_base;
			col_next = '0;
			cnt_next = '0;
		end else begin
			row_next = row_base;
			col_next = (col_base < COUNT_MAX) ? col_base + count_t'(1) : col_base;
			cnt_next = hit ? '0 : cnt_inc;
		end
	end

	assign advance  = valid_s1 && (!hit || !out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= text_byte;
			start_s1 <= file_start;
			file_s1  <= file_number;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cnt_q <= '0;
			row_q     <= count_t'(1);
			col_q     <= '0;
		end else if (advance) begin
			win_cnt_q <= cnt_next;
			row_q     <= row_next;
			col_q     <= col_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++)
				win_q[k] <= '0;
		end else if (advance && !is_newline) begin
			for (int k = 0; k < MAX_PATTERN; k++)
				win_q[k] <= win_next[k];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (advance && hit)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			match_file   <= file_s1;
			match_row    <= row_next;
			match_column <= col_next - count_t'(len) + count_t'(1);
		end
	end

	a_row_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		row_q != '0)
		else $error("row counter reached zero");

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		win_cnt_q <= LEN_MAX)
		else $error("window count above maximum");

	a_hit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance && hit |=> out_valid)
		else $error("match not loaded into result register");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty input stage not ready");

	a_newline_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_newline |=> win_cnt_q == '0 && col_q == '0)
		else $error("newline did not clear line state");

endmodule
